// File: design/ttk_pkg.sv
// Shared types and constants for the text map tokenizer.
// Used by ttk_lexer, ttk_out and text_map_tokenizer; no dependencies.
package ttk_pkg;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] SPACE_MAX    = 8'd32;
  localparam logic [7:0] DEL_LO       = 8'd127;
  localparam logic [7:0] DEL_HI       = 8'd160;

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic [1:0] tok_kind;
    logic       tok_first;
    logic       tok_end;
    logic       stream_done;
  } tok_t;

  // Up to three results of one input beat, slot 0 goes out first.
  typedef struct packed {
    tok_t [2:0] slot;
    logic [1:0] cnt;
  } tok_bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c <= SPACE_MAX) || ((c >= DEL_LO) && (c <= DEL_HI));
  endfunction

  function automatic logic word_start(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F, 8'h2D, 8'h2B});
  endfunction

endpackage

// File: design/text_map_tokenizer.sv
// Top level of the text map tokenizer: C-style lexer over a byte stream.
// Depends on ttk_pkg, ttk_lexer and ttk_out.
//
// One text byte is taken per beat and each beat yields zero to three result beats
// (token bytes, then the end-of-stream marker when tlast was set); m_axis_tlast marks
// the last result of an input beat. The lexer state updates in the accepting cycle and its
// results land in a three-slot output register, so an input beat is taken every cycle as
// long as each one yields at most one result and the output is ready; a beat with more
// results holds the input while the register drains one beat a cycle whenever ready.
module text_map_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tok_byte, [8] tok_first, [9] tok_end, zero fill
  output logic [2:0]  m_axis_tuser,   // [1:0] tok_kind, [2] stream_done
  output logic        m_axis_tlast    // run_last
);

  ttk_pkg::tok_bundle_t bundle;
  ttk_pkg::tok_t        tok;
  logic                 accept;
  logic                 can_load;

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  ttk_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .bundle     (bundle)
  );

  ttk_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (tok),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, tok.tok_end, tok.tok_first, tok.tok_byte};
  assign m_axis_tuser = {tok.stream_done, tok.tok_kind};

endmodule

// File: design/ttk_lexer.sv
// Lexer state and per-beat token decision for the text map tokenizer.
// Depends on ttk_pkg; feeds a result bundle to ttk_out.
module ttk_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               final_byte,
  output ttk_pkg::tok_bundle_t bundle
);

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_WORD, M_STR, M_ESC, M_BLK, M_BSTAR, M_LINE
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_first, held_first_next;

  // boundary decision for the current byte
  logic         b_emit;
  ttk_pkg::tok_t b_tok;
  mode_t        b_mode;
  logic         b_hold;

  always_comb begin
    b_emit = 1'b0;
    b_hold = 1'b0;
    b_mode = M_IDLE;
    b_tok  = '{tok_byte: in_byte, tok_kind: ttk_pkg::KIND_SYMBOL, tok_first: 1'b1,
               tok_end: 1'b1, stream_done: 1'b0};
    if (ttk_pkg::is_space(in_byte)) begin
      b_emit = 1'b0;
    end else if (in_byte == ttk_pkg::CH_SLASH) begin
      if (final_byte) begin
        b_emit = 1'b1;
      end else begin
        b_hold = 1'b1;
        b_mode = M_SLASH;
      end
    end else if (in_byte == ttk_pkg::CH_QUOTE) begin
      b_emit         = 1'b1;
      b_tok.tok_kind = ttk_pkg::KIND_TEXT;
      b_tok.tok_end  = final_byte;
      b_mode         = final_byte ? M_IDLE : M_STR;
    end else if (ttk_pkg::word_start(in_byte)) begin
      b_tok.tok_kind = ttk_pkg::KIND_WORD;
      if (final_byte) begin
        b_emit = 1'b1;
      end else begin
        b_hold = 1'b1;
        b_mode = M_WORD;
      end
    end else begin
      b_emit = 1'b1;
    end
  end

  ttk_pkg::tok_t [2:0] res;
  logic [1:0]          n;
  ttk_pkg::tok_t       held_tok;
  logic                use_bnd;

  always_comb begin
    res             = '0;
    n               = 2'd0;
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_first_next = held_first;
    use_bnd         = 1'b0;
    held_tok        = '{tok_byte: held_byte, tok_kind: ttk_pkg::KIND_SYMBOL, tok_first: 1'b1,
                        tok_end: 1'b1, stream_done: 1'b0};
    case (mode)
      M_IDLE: begin
        use_bnd = 1'b1;
      end
      M_SLASH: begin
        if (in_byte == ttk_pkg::CH_STAR) begin
          mode_next = M_BLK;
        end else if (in_byte == ttk_pkg::CH_SLASH) begin
          mode_next = M_LINE;
        end else begin
          res[n] = held_tok;
          n      = n + 2'd1;
          use_bnd = 1'b1;
        end
      end
      M_WORD: begin
        held_tok.tok_kind  = ttk_pkg::KIND_WORD;
        held_tok.tok_first = held_first;
        if (ttk_pkg::word_start(in_byte) || in_byte == ttk_pkg::CH_DOT) begin
          held_tok.tok_end = 1'b0;
          res[n] = held_tok;
          n      = n + 2'd1;
          if (final_byte) begin
            res[n] = '{tok_byte: in_byte, tok_kind: ttk_pkg::KIND_WORD, tok_first: 1'b0,
                       tok_end: 1'b1, stream_done: 1'b0};
            n      = n + 2'd1;
          end else begin
            held_byte_next  = in_byte;
            held_first_next = 1'b0;
          end
        end else begin
          res[n] = held_tok;
          n      = n + 2'd1;
          use_bnd = 1'b1;
        end
      end
      M_STR: begin
        res[n] = '{tok_byte: in_byte, tok_kind: ttk_pkg::KIND_TEXT, tok_first: 1'b0,
                   tok_end: final_byte, stream_done: 1'b0};
        if (in_byte == ttk_pkg::CH_QUOTE) begin
          res[n].tok_end = 1'b1;
          mode_next      = M_IDLE;
        end else if (in_byte == ttk_pkg::CH_BACKSLASH) begin
          mode_next = M_ESC;
        end
        n = n + 2'd1;
      end
      M_ESC: begin
        res[n] = '{tok_byte: in_byte, tok_kind: ttk_pkg::KIND_TEXT, tok_first: 1'b0,
                   tok_end: final_byte, stream_done: 1'b0};
        n         = n + 2'd1;
        mode_next = M_STR;
      end
      M_BLK: begin
        if (in_byte == ttk_pkg::CH_STAR) begin
          mode_next = M_BSTAR;
        end
      end
      M_BSTAR: begin
        if (in_byte == ttk_pkg::CH_SLASH) begin
          mode_next = M_IDLE;
        end else if (in_byte != ttk_pkg::CH_STAR) begin
          mode_next = M_BLK;
        end
      end
      M_LINE: begin
        if (in_byte == ttk_pkg::CH_NEWLINE) begin
          mode_next = M_IDLE;
        end
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    if (use_bnd) begin
      mode_next = b_mode;
      if (b_emit) begin
        res[n] = b_tok;
        n      = n + 2'd1;
      end
      if (b_hold) begin
        held_byte_next  = in_byte;
        held_first_next = 1'b1;
      end
    end

    if (final_byte) begin
      res[n] = '{tok_byte: 8'd0, tok_kind: ttk_pkg::KIND_TEXT, tok_first: 1'b0,
                 tok_end: 1'b0, stream_done: 1'b1};
      n               = n + 2'd1;
      mode_next       = M_IDLE;
      held_byte_next  = 8'd0;
      held_first_next = 1'b0;
    end
  end

  assign bundle.slot = res;
  assign bundle.cnt  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      held_byte  <= 8'd0;
      held_first <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_first <= held_first_next;
    end
  end

endmodule

// File: design/ttk_out.sv
// Result register for the text map tokenizer: holds one bundle, drains one beat a cycle while out_ready is high.
// Depends on ttk_pkg; loaded from ttk_lexer.
module ttk_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ttk_pkg::tok_bundle_t bundle,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttk_pkg::tok_t        out_tok,
  output logic                 out_last
);

  ttk_pkg::tok_t [2:0] slot;
  logic [1:0]          cnt;
  logic                take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && out_ready;
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign out_tok   = slot[0];
  assign out_last  = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle.slot;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule
